[sv/bfe_pkg.sv]
// Shared constants, types and helper functions of the badge frame encoder.
package bfe_pkg;

    // Field widths
    localparam int unsigned SubtypeW = 4;
    localparam int unsigned CodeW    = 12;
    localparam int unsigned NumberW  = 17;
    localparam int unsigned WordW    = 64;
    localparam int unsigned BodyW    = 56;
    localparam int unsigned DigitW   = 4;
    localparam int unsigned BcdW     = 5 * DigitW;
    localparam int unsigned CrcW     = 16;

    // Frame constants
    localparam logic [NumberW-1:0] BadgeMax     = 17'd99999;
    localparam logic [7:0]         HeadMark     = 8'hC0;
    localparam logic [7:0]         PreambleByte = 8'hFE;
    localparam logic [7:0]         FixHi        = 8'h71;
    localparam logic [7:0]         FixLo        = 8'h40;
    localparam logic [CrcW-1:0]    CrcPoly      = 16'h1021;

    // Decimal place weights
    localparam logic [NumberW-1:0] Unit10k = 17'd10000;
    localparam logic [NumberW-1:0] Unit1k  = 17'd1000;
    localparam logic [NumberW-1:0] Unit100 = 17'd100;
    localparam logic [NumberW-1:0] Unit10  = 17'd10;

    // Queue between front and back
    localparam int unsigned QueueDepth = 2;
    localparam int unsigned QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

    // Classified item handed from front to back
    typedef struct packed {
        logic             bad;
        logic             long_frame;
        logic [BodyW-1:0] body;   // interleaved 7-byte buffer
        logic [BcdW-1:0]  bcd;    // d0..d4, most significant first
    } bfe_item_t;

    // One byte of CRC-16/XMODEM, MSB first
    function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc_in,
                                                 input logic [7:0] data);
        logic [CrcW-1:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int b = 0; b < 8; b++)
        begin
            c = c[CrcW-1] ? ({c[CrcW-2:0], 1'b0} ^ CrcPoly) : {c[CrcW-2:0], 1'b0};
        end
        return c;
    endfunction

    // Largest q in 0..9 with q*unit <= value (parallel compares)
    function automatic logic [DigitW-1:0] digit_of(input logic [NumberW-1:0] value,
                                                   input logic [NumberW-1:0] unit);
        logic [DigitW-1:0] q;
        logic [20:0]       lim;
        q   = '0;
        lim = '0;
        for (int k = 1; k < 10; k++)
        begin
            lim = 21'(k) * {4'b0, unit};
            if ({4'b0, value} >= lim)
            begin
                q = DigitW'(k);
            end
        end
        return q;
    endfunction

    // value - q*unit
    function automatic logic [NumberW-1:0] digit_rem(input logic [NumberW-1:0] value,
                                                     input logic [DigitW-1:0] q,
                                                     input logic [NumberW-1:0] unit);
        logic [NumberW-1:0] prod;
        prod = NumberW'({13'b0, q} * unit);
        return value - prod;
    endfunction

    // (c + 1 + d) mod 10 for c, d in 0..9
    function automatic logic [DigitW-1:0] chain_step(input logic [DigitW-1:0] c,
                                                     input logic [DigitW-1:0] d);
        logic [4:0] s;
        s = {1'b0, c} + {1'b0, d} + 5'd1;
        return (s >= 5'd10) ? DigitW'(s - 5'd10) : s[DigitW-1:0];
    endfunction

    // Chained digit to nibble translation
    function automatic logic [DigitW-1:0] digit_code(input logic [DigitW-1:0] c);
        logic [DigitW-1:0] n;
        case (c)
            4'd0:    n = 4'd8;
            4'd1:    n = 4'd2;
            4'd2:    n = 4'd1;
            4'd3:    n = 4'd12;
            4'd4:    n = 4'd4;
            4'd5:    n = 4'd5;
            4'd6:    n = 4'd10;
            4'd7:    n = 4'd13;
            4'd8:    n = 4'd0;
            4'd9:    n = 4'd9;
            default: n = 4'd0;
        endcase
        return n;
    endfunction

    // Even parity over bits 63..1 placed in bit 0
    function automatic logic [WordW-1:0] add_parity(input logic [WordW-1:0] w);
        return {w[WordW-1:1], ^w[WordW-1:1]};
    endfunction

endpackage

[sv/bfe_ifs.sv]
// Valid/ready channel interfaces for badge requests and frame words.
interface bfe_req_if;
    import bfe_pkg::*;

    logic                valid;
    logic                ready;
    logic [SubtypeW-1:0] subtype;
    logic [CodeW-1:0]    customer_code;
    logic [NumberW-1:0]  badge_number;
    logic                long_frame;

    modport source (output valid, subtype, customer_code, badge_number, long_frame,
                    input ready);
    modport sink   (input valid, subtype, customer_code, badge_number, long_frame,
                    output ready);
endinterface

interface bfe_frame_if;
    import bfe_pkg::*;

    logic             valid;
    logic             ready;
    logic [WordW-1:0] frame_word;
    logic             last_word;
    logic             bad_number;

    modport source (output valid, frame_word, last_word, bad_number, input ready);
    modport sink   (input valid, frame_word, last_word, bad_number, output ready);
endinterface

[sv/bfe_front.sv]
// Front pipeline: range check, decimal split, digit chaining and header CRC.
module bfe_front
(
    input  logic               clk,
    input  logic               rst_n,
    bfe_req_if.sink            request,
    output logic               push_valid,
    input  logic               push_ready,
    output bfe_pkg::bfe_item_t push_item
);
    import bfe_pkg::*;

    // Stage payloads
    typedef struct packed {
        logic              bad;
        logic              long_frame;
        logic [23:0]       head;     // h0, h1, h2
        logic [DigitW-1:0] d0;
        logic [13:0]       rem;      // below 10000
        logic [CrcW-1:0]   crc;      // after h0
    } s1_t;

    typedef struct packed {
        logic              bad;
        logic              long_frame;
        logic [23:0]       head;
        logic [DigitW-1:0] d0;
        logic [DigitW-1:0] d1;
        logic [DigitW-1:0] c1;
        logic [9:0]        rem;      // below 1000
        logic [CrcW-1:0]   crc;      // after h1
    } s2_t;

    typedef struct packed {
        logic              bad;
        logic              long_frame;
        logic [23:0]       head;
        logic [DigitW-1:0] d0;
        logic [DigitW-1:0] d1;
        logic [DigitW-1:0] d2;
        logic [DigitW-1:0] c1;
        logic [DigitW-1:0] c2;
        logic [6:0]        rem;      // below 100
        logic [CrcW-1:0]   crc;      // after h2
    } s3_t;

    typedef struct packed {
        logic              bad;
        logic              long_frame;
        logic [23:0]       head;
        logic [7:0]        h3;
        logic [BcdW-1:0]   bcd;
        logic [DigitW-1:0] c3;
        logic [DigitW-1:0] c4;
        logic [CrcW-1:0]   crc;      // after h3
    } s4_t;

    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic s3_valid_reg, s3_valid_next;
    logic s4_valid_reg, s4_valid_next;
    s1_t  s1_reg, s1_next;
    s2_t  s2_reg, s2_next;
    s3_t  s3_reg, s3_next;
    s4_t  s4_reg, s4_next;

    logic rdy1, rdy2, rdy3, rdy4;
    logic [NumberW-1:0] num;
    logic [7:0]         h0;
    logic [7:0]         h4;
    logic [DigitW-1:0]  d3;
    logic [DigitW-1:0]  d4;
    logic [CrcW-1:0]    crc_final;

    // Stage ready chain
    assign rdy4 = !s4_valid_reg || push_ready;
    assign rdy3 = !s3_valid_reg || rdy4;
    assign rdy2 = !s2_valid_reg || rdy3;
    assign rdy1 = !s1_valid_reg || rdy2;
    assign request.ready = rdy1;

    assign s1_valid_next = rdy1 ? request.valid : s1_valid_reg;
    assign s2_valid_next = rdy2 ? s1_valid_reg  : s2_valid_reg;
    assign s3_valid_next = rdy3 ? s2_valid_reg  : s3_valid_reg;
    assign s4_valid_next = rdy4 ? s3_valid_reg  : s4_valid_reg;

    // Stage 1: classify, ten-thousands digit, CRC over h0
    always_comb
    begin
        num = request.badge_number;
        h0  = HeadMark | {4'b0, request.subtype};
        s1_next.bad        = (num == '0) || (num > BadgeMax);
        s1_next.long_frame = request.long_frame;
        s1_next.d0         = digit_of(num, Unit10k);
        s1_next.rem        = 14'(digit_rem(num, s1_next.d0, Unit10k));
        s1_next.head       = {h0, request.customer_code,
                              digit_code(s1_next.d0)};
        s1_next.crc        = crc_byte('0, h0);
    end

    // Stage 2: thousands digit, first chain step, CRC over h1
    always_comb
    begin
        s2_next.bad        = s1_reg.bad;
        s2_next.long_frame = s1_reg.long_frame;
        s2_next.head       = s1_reg.head;
        s2_next.d0         = s1_reg.d0;
        s2_next.d1         = digit_of({3'b0, s1_reg.rem}, Unit1k);
        s2_next.rem        = 10'(digit_rem({3'b0, s1_reg.rem}, s2_next.d1, Unit1k));
        s2_next.c1         = chain_step(s1_reg.d0, s2_next.d1);
        s2_next.crc        = crc_byte(s1_reg.crc, s1_reg.head[15:8]);
    end

    // Stage 3: hundreds digit, second chain step, CRC over h2
    always_comb
    begin
        s3_next.bad        = s2_reg.bad;
        s3_next.long_frame = s2_reg.long_frame;
        s3_next.head       = s2_reg.head;
        s3_next.d0         = s2_reg.d0;
        s3_next.d1         = s2_reg.d1;
        s3_next.d2         = digit_of({7'b0, s2_reg.rem}, Unit100);
        s3_next.rem        = 7'(digit_rem({7'b0, s2_reg.rem}, s3_next.d2, Unit100));
        s3_next.c1         = s2_reg.c1;
        s3_next.c2         = chain_step(s2_reg.c1, s3_next.d2);
        s3_next.crc        = crc_byte(s2_reg.crc, s2_reg.head[7:0]);
    end

    // Stage 4: tens and units, last chain steps, CRC over h3
    always_comb
    begin
        d3 = digit_of({10'b0, s3_reg.rem}, Unit10);
        d4 = 4'(digit_rem({10'b0, s3_reg.rem}, d3, Unit10));
        s4_next.bad        = s3_reg.bad;
        s4_next.long_frame = s3_reg.long_frame;
        s4_next.head       = s3_reg.head;
        s4_next.h3         = {digit_code(s3_reg.c1), digit_code(s3_reg.c2)};
        s4_next.bcd        = {s3_reg.d0, s3_reg.d1, s3_reg.d2, d3, d4};
        s4_next.c3         = chain_step(s3_reg.c2, d3);
        s4_next.c4         = chain_step(s4_next.c3, d4);
        s4_next.crc        = crc_byte(s3_reg.crc, s4_next.h3);
    end

    // Finish: CRC over h4 and nibble interleave
    always_comb
    begin
        h4        = {digit_code(s4_reg.c3), digit_code(s4_reg.c4)};
        crc_final = crc_byte(s4_reg.crc, h4);
        push_item.bad        = s4_reg.bad;
        push_item.long_frame = s4_reg.long_frame;
        push_item.bcd        = s4_reg.bcd;
        push_item.body       = {s4_reg.head,
                                crc_final[15:12], s4_reg.h3[7:4],
                                crc_final[11:8],  s4_reg.h3[3:0],
                                crc_final[7:4],   h4[7:4],
                                crc_final[3:0],   h4[3:0]};
    end

    assign push_valid = s4_valid_reg;

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
            s4_valid_reg <= s4_valid_next;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (rdy1 && request.valid)
        begin
            s1_reg <= s1_next;
        end
        if (rdy2 && s1_valid_reg)
        begin
            s2_reg <= s2_next;
        end
        if (rdy3 && s2_valid_reg)
        begin
            s3_reg <= s3_next;
        end
        if (rdy4 && s3_valid_reg)
        begin
            s4_reg <= s4_next;
        end
    end

endmodule

[sv/bfe_queue.sv]
// Short register queue between the front pipeline and the word builder.
module bfe_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  bfe_pkg::bfe_item_t push_item,
    output logic               pop_valid,
    input  logic               pop_ready,
    output bfe_pkg::bfe_item_t pop_item
);
    import bfe_pkg::*;

    bfe_item_t              mem_reg [QueueDepth];
    logic [QueuePtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QueuePtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QueueCntW-1:0]   count_reg, count_next;
    logic                   do_push, do_pop;

    assign push_ready = (count_reg != QueueCntW'(QueueDepth));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QueuePtrW'(QueueDepth - 1)) ? '0
                                                                    : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QueuePtrW'(QueueDepth - 1)) ? '0
                                                                    : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[sv/bfe_back.sv]
// Back end: builds frame words with parity and sequences one or two per item.
module bfe_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  bfe_pkg::bfe_item_t pop_item,
    bfe_frame_if.source        frame
);
    import bfe_pkg::*;

    logic             out_valid_reg, out_valid_next;
    logic             pend_reg, pend_next;
    logic [WordW-1:0] word_reg, word_next;
    logic             last_reg, last_next;
    logic             bad_reg, bad_next;
    logic [WordW-1:0] pend_word_reg, pend_word_next;
    logic             slot_free;
    logic             take;
    logic [WordW-1:0] first_word;
    logic [WordW-1:0] second_word;

    assign slot_free = !out_valid_reg || frame.ready;
    assign pop_ready = slot_free && !pend_reg;
    assign take      = pop_ready && pop_valid;

    // Word images for the item at the queue head
    always_comb
    begin
        first_word  = add_parity({PreambleByte[7:1], pop_item.body, 1'b0});
        second_word = add_parity({1'b0, pop_item.bcd[7:0],
                                  1'b0, pop_item.bcd[15:8],
                                  1'b0, 4'b0, pop_item.bcd[19:16],
                                  1'b0, FixHi,
                                  1'b0, FixLo,
                                  1'b0, 8'h00,
                                  1'b0, 8'h00,
                                  1'b0});
    end

    // Output register load: pending second word first, then the next item
    always_comb
    begin
        out_valid_next = out_valid_reg;
        pend_next      = pend_reg;
        word_next      = word_reg;
        last_next      = last_reg;
        bad_next       = bad_reg;
        pend_word_next = pend_word_reg;
        if (slot_free)
        begin
            out_valid_next = 1'b0;
            if (pend_reg)
            begin
                out_valid_next = 1'b1;
                word_next      = pend_word_reg;
                last_next      = 1'b1;
                bad_next       = 1'b0;
                pend_next      = 1'b0;
            end
            else if (take)
            begin
                out_valid_next = 1'b1;
                word_next      = pop_item.bad ? '0 : first_word;
                last_next      = pop_item.bad || !pop_item.long_frame;
                bad_next       = pop_item.bad;
                pend_next      = !pop_item.bad && pop_item.long_frame;
                pend_word_next = second_word;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg      <= word_next;
        last_reg      <= last_next;
        bad_reg       <= bad_next;
        pend_word_reg <= pend_word_next;
    end

    assign frame.valid      = out_valid_reg;
    assign frame.frame_word = word_reg;
    assign frame.last_word  = last_reg;
    assign frame.bad_number = bad_reg;

endmodule

[sv/badge_frame_encoder.sv]
// Badge frame encoder: top level joining front pipeline, queue and word builder.
//
// Usage:
//   request carries subtype, customer_code, badge_number and long_frame; an item
//   is taken at a clock edge where request.valid and request.ready are high.
//   frame returns 64-bit words, first sent bit in the MSB. A short frame gives
//   one word; a long frame gives two, the second flagged by last_word. A badge
//   number of zero or above 99999 gives a single all-zero word with bad_number
//   and last_word set.
// Path: the first word passes the four front stages, the queue, then the
//   output register.
// Throughput: one word per cycle while frame.ready is high, so one item per
//   cycle for short frames, while a long frame's second word holds off the
//   next item; the single output register is the limit. The front accepts an
//   item per cycle until its four stages and the 2-entry queue are full.
// Reset: rst_n clears all valid bits; no words are pending afterwards and
//   request.ready is high.
// Stall: while frame.ready is low the output word holds; the queue and then the
//   front stages fill, after which request.ready drops.
module badge_frame_encoder
(
    input  logic        clk,
    input  logic        rst_n,
    bfe_req_if.sink     request,
    bfe_frame_if.source frame
);
    import bfe_pkg::*;

    logic      push_valid, push_ready;
    logic      pop_valid, pop_ready;
    bfe_item_t push_item, pop_item;

    bfe_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .request    (request),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    bfe_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    bfe_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .frame     (frame)
    );

endmodule

[sv/bfe_checker.sv]
// Port-level assertions for the badge frame encoder, bound to the top level.
module bfe_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] frame_word,
    input logic        last_word,
    input logic        bad_number
);

    // A rejected number is a single zero word
    a_bad_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_number |-> frame_word == '0 && last_word)
        else $error("rejected item word not zero or not last");

    // Every word has even parity over all 64 bits
    a_parity: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ^frame_word == 1'b0)
        else $error("frame word parity odd");

    // The second word of a long frame follows right after the first
    a_second_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_word |=> out_valid && last_word && !bad_number)
        else $error("second word of long frame missing");

    // A stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(frame_word) && $stable(last_word))
        else $error("output word changed under stall");

endmodule

bind badge_frame_encoder bfe_checker u_bfe_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (frame.valid),
    .out_ready  (frame.ready),
    .frame_word (frame.frame_word),
    .last_word  (frame.last_word),
    .bad_number (frame.bad_number)
);
